@@ rtl/core/linkage_code_table_unit_macros.svh @@
// Assertion macros shared by the linkage code table RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef LINKAGE_CODE_TABLE_UNIT_MACROS_SVH
`define LINKAGE_CODE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("linkage code table check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define LCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("linkage code table check failed");

`endif

@@ rtl/core/lct_pkg.sv @@
// Types and constants of the linkage code table.
// No dependencies; used by linkage_code_table_unit.
package lct_pkg;

  localparam int CODE_W   = 16;
  localparam int COUNT_W  = 6;
  localparam int LSN_W    = 12;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int OCC_W    = 5;

  localparam logic [COUNT_W-1:0] AGE_LIMIT     = COUNT_W'(32);
  localparam logic [COUNT_W-1:0] REPLACE_BELOW = COUNT_W'(2);

  typedef enum logic [1:0] {
    KIND_OBSERVE = 2'd0,
    KIND_LINK    = 2'd1,
    KIND_ACTUATE = 2'd2
  } lct_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT      = 3'd0,
    STATUS_INSERTED = 3'd1,
    STATUS_REPLACED = 3'd2,
    STATUS_MISS     = 3'd3,
    STATUS_ACTUATOR = 3'd4
  } lct_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_CLEAR
  } lct_state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] program_code;
    logic              actuator_bit;
    logic              extended_bit;
    logic              international_bit;
    logic [LSN_W-1:0]  set_number;
  } lct_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                general_actuator;
    logic [OCC_W-1:0]    occupied;
    logic                aged;
  } lct_result_t;

  // One table entry as it is kept in memory.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
    logic               actuator;
    logic               extended;
    logic               international;
    logic [LSN_W-1:0]   set_number;
  } lct_entry_t;

endpackage

@@ rtl/core/linkage_code_table_unit.sv @@
// Linkage code table: top level with the sequencer and one entry RAM.
// Depends on lct_pkg, lct_ram and linkage_code_table_unit_macros.svh.
//
// Usage. An item is transferred at a rising edge where start_i is high and busy_o
// is low. Kind 0 observes a programme code (hit, insert, replace or drop), kind 1
// stores linkage fields into the entry holding the code, kind 2 sets or clears the
// general actuator. Every item yields exactly one result, shown on result_o for
// one cycle with result_valid_o high; the receiver cannot stall it.
// Every item but an actuator set or an unused kind walks the entry RAM, one read
// per cycle through its single read port. An observation reads the entries in use
// and the slot after them if any, then writes at most one entry; when its hit
// pushes a count to 32, the table is halved and compacted in a second walk. A
// linkage item reads the entries in use (none on an empty table); clearing the
// actuators reads and rewrites every entry. busy_o falls in the cycle the result
// is shown, so the next item can be transferred then.
// Reset empties the table at once: per-entry written bits make never-written
// entries read as zero, so no clearing pass is needed.
module linkage_code_table_unit
  import lct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  lct_item_t   item_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output lct_result_t result_o
);

`include "linkage_code_table_unit_macros.svh"

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int N_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = $bits(lct_entry_t);
  localparam logic [N_W-1:0]   N_FULL   = N_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  lct_state_e  state_q, state_d;
  lct_item_t   item_q, item_d;
  logic [N_W-1:0]   n_q, n_d;
  logic             flag_q, flag_d;
  logic [TABLE_ENTRIES-1:0] written_q;

  // Sweep control: read issue counter and the tag of the data coming back.
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic             iss_q, iss_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] rtag_q, rtag_d;

  // Scan results.
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  lct_entry_t       hit_ent_q, hit_ent_d;
  logic [IDX_W-1:0] min_idx_q, min_idx_d;
  lct_entry_t       min_ent_q, min_ent_d;
  lct_entry_t       free_ent_q, free_ent_d;
  logic             any_q, any_d;

  // Aging.
  logic [IDX_W-1:0] track_q, track_d;
  logic [N_W-1:0]   w_q, w_d;
  logic [IDX_W-1:0] moved_q, moved_d;

  logic        res_valid_q, res_valid_d;
  lct_result_t res_q, res_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  lct_entry_t         ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  lct_entry_t         rd_ent;

  logic               data_last;
  logic               tag_in_use;
  logic [COUNT_W-1:0] hit_cnt_inc;
  logic [COUNT_W-1:0] half_cnt;
  logic               age_needed;

  logic               fin;
  lct_status_e        fin_status;
  logic [IDX_W-1:0]   fin_slot;
  logic               fin_aged;

  lct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // An entry that was never written holds its reset value of zero.
  assign rd_ent      = written_q[rtag_q] ? lct_entry_t'(ram_rdata) : '0;
  assign data_last   = rv_q && (rtag_q == last_q);
  assign tag_in_use  = N_W'(rtag_q) < n_q;
  assign hit_cnt_inc = hit_ent_q.count + 1'b1;
  assign half_cnt    = rd_ent.count >> 1;
  assign age_needed  = hit_cnt_inc >= AGE_LIMIT;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (item_i.kind)
            KIND_OBSERVE: state_d = ST_SCAN;
            KIND_LINK:    state_d = (n_q != '0) ? ST_SCAN : ST_DECIDE;
            KIND_ACTUATE: state_d = item_i.actuator_bit ? ST_IDLE : ST_CLEAR;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (data_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (item_q.kind == KIND_OBSERVE && found_q && age_needed) begin
          state_d = ST_AGE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_AGE: begin
        if (data_last) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (data_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory port and result.
  always_comb begin
    item_d     = item_q;
    n_d        = n_q;
    flag_d     = flag_q;
    rd_idx_d   = rd_idx_q;
    last_d     = last_q;
    iss_d      = iss_q;
    rv_d       = iss_q;
    rtag_d     = rd_idx_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_ent_d  = hit_ent_q;
    min_idx_d  = min_idx_q;
    min_ent_d  = min_ent_q;
    free_ent_d = free_ent_q;
    any_d      = any_q;
    track_d    = track_q;
    w_d        = w_q;
    moved_d    = moved_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    fin        = 1'b0;
    fin_status = STATUS_MISS;
    fin_slot   = '0;
    fin_aged   = 1'b0;

    // One read is issued per cycle while a sweep runs.
    if (iss_q) begin
      if (rd_idx_q == last_q) begin
        iss_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          found_d  = 1'b0;
          any_d    = 1'b0;
          rd_idx_d = '0;
          case (item_i.kind)
            KIND_OBSERVE: begin
              // Unless full, the slot after the last entry is read too, for its linkage fields.
              last_d = (n_q == N_FULL) ? IDX_LAST : n_q[IDX_W-1:0];
              iss_d  = 1'b1;
            end
            KIND_LINK: begin
              if (n_q != '0) begin
                last_d = IDX_W'(n_q - 1'b1);
                iss_d  = 1'b1;
              end
            end
            KIND_ACTUATE: begin
              flag_d = item_i.actuator_bit;
              if (item_i.actuator_bit) begin
                fin        = 1'b1;
                fin_status = STATUS_ACTUATOR;
              end else begin
                last_d = IDX_LAST;
                iss_d  = 1'b1;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = STATUS_MISS;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rv_q) begin
          if (tag_in_use) begin
            if (rd_ent.code == item_q.program_code && !found_q) begin
              found_d   = 1'b1;
              hit_idx_d = rtag_q;
              hit_ent_d = rd_ent;
            end else begin
              any_d = any_q | rd_ent.actuator;
            end
            // The first entry with the lowest count wins.
            if (rtag_q == '0 || rd_ent.count < min_ent_q.count) begin
              min_idx_d = rtag_q;
              min_ent_d = rd_ent;
            end
          end else begin
            free_ent_d = rd_ent;
          end
        end
      end

      ST_DECIDE: begin
        if (item_q.kind == KIND_OBSERVE) begin
          if (found_q) begin
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_q;
            ram_wdata       = hit_ent_q;
            ram_wdata.count = hit_cnt_inc;
            if (age_needed) begin
              track_d  = hit_idx_q;
              w_d      = '0;
              moved_d  = '0;
              rd_idx_d = '0;
              last_d   = IDX_W'(n_q - 1'b1);
              iss_d    = 1'b1;
            end else begin
              fin        = 1'b1;
              fin_status = STATUS_HIT;
              fin_slot   = hit_idx_q;
            end
          end else if (n_q != N_FULL) begin
            ram_we          = 1'b1;
            ram_waddr       = n_q[IDX_W-1:0];
            ram_wdata       = free_ent_q;
            ram_wdata.code  = item_q.program_code;
            ram_wdata.count = COUNT_W'(1);
            n_d             = n_q + 1'b1;
            fin             = 1'b1;
            fin_status      = STATUS_INSERTED;
            fin_slot        = n_q[IDX_W-1:0];
          end else if (min_ent_q.count < REPLACE_BELOW) begin
            // The replaced entry keeps its linkage fields; its count goes up by one.
            ram_we          = 1'b1;
            ram_waddr       = min_idx_q;
            ram_wdata       = min_ent_q;
            ram_wdata.code  = item_q.program_code;
            ram_wdata.count = min_ent_q.count + 1'b1;
            fin             = 1'b1;
            fin_status      = STATUS_REPLACED;
            fin_slot        = min_idx_q;
          end else begin
            fin        = 1'b1;
            fin_status = STATUS_MISS;
          end
        end else if (found_q) begin
          ram_we                  = 1'b1;
          ram_waddr               = hit_idx_q;
          ram_wdata               = hit_ent_q;
          ram_wdata.actuator      = item_q.actuator_bit;
          ram_wdata.extended      = item_q.extended_bit;
          ram_wdata.international = item_q.international_bit;
          ram_wdata.set_number    = item_q.set_number;
          if (item_q.actuator_bit) begin
            flag_d = 1'b1;
          end else if (!any_q) begin
            flag_d = 1'b0;
          end
          fin        = 1'b1;
          fin_status = STATUS_HIT;
          fin_slot   = hit_idx_q;
        end else begin
          fin        = 1'b1;
          fin_status = STATUS_MISS;
        end
      end

      ST_AGE: begin
        // Writes trail reads, so the write address never passes the read address.
        if (rv_q) begin
          if (half_cnt != '0) begin
            ram_we          = 1'b1;
            ram_waddr       = w_q[IDX_W-1:0];
            ram_wdata       = rd_ent;
            ram_wdata.count = half_cnt;
            w_d             = w_q + 1'b1;
            if (rtag_q == track_q) moved_d = w_q[IDX_W-1:0];
          end
          if (data_last) begin
            n_d        = w_d;
            fin        = 1'b1;
            fin_status = STATUS_HIT;
            fin_slot   = moved_d;
            fin_aged   = 1'b1;
          end
        end
      end

      ST_CLEAR: begin
        if (rv_q) begin
          ram_we             = 1'b1;
          ram_waddr          = rtag_q;
          ram_wdata          = rd_ent;
          ram_wdata.actuator = 1'b0;
          if (data_last) begin
            fin        = 1'b1;
            fin_status = STATUS_ACTUATOR;
          end
        end
      end

      default: begin
        fin = 1'b0;
      end
    endcase

    res_valid_d = fin;
    if (fin) begin
      res_d.status           = fin_status;
      res_d.slot             = SLOT_W'(fin_slot);
      res_d.general_actuator = flag_d;
      res_d.occupied         = OCC_W'(n_d);
      res_d.aged             = fin_aged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      flag_q      <= 1'b0;
      written_q   <= '0;
      rd_idx_q    <= '0;
      last_q      <= '0;
      iss_q       <= 1'b0;
      rv_q        <= 1'b0;
      rtag_q      <= '0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      flag_q      <= flag_d;
      rd_idx_q    <= rd_idx_d;
      last_q      <= last_d;
      iss_q       <= iss_d;
      rv_q        <= rv_d;
      rtag_q      <= rtag_d;
      found_q     <= found_d;
      any_q       <= any_d;
      res_valid_q <= res_valid_d;
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    min_idx_q  <= min_idx_d;
    min_ent_q  <= min_ent_d;
    free_ent_q <= free_ent_d;
    track_q    <= track_d;
    w_q        <= w_d;
    moved_q    <= moved_d;
    res_q      <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `LCT_ASSERT_IMPL(a_occ_bound, 1'b1, n_q <= N_FULL)
  `LCT_ASSERT_IMPL(a_result_when_idle, res_valid_q, state_q == ST_IDLE)
  `LCT_ASSERT_NEXT(a_transfer_answered, start_i && !busy_o, busy_o || result_valid_o)
  `LCT_ASSERT_IMPL(a_no_idle_write, ram_we, state_q != ST_IDLE)
  `LCT_ASSERT_IMPL(a_compact_trails, (state_q == ST_AGE) && ram_we, ram_waddr <= rtag_q)

endmodule

@@ rtl/core/lct_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lct_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_linkage_code_table_unit.sv @@
// Self-checking testbench for linkage_code_table_unit: directed rows, then random
// code observations, linkage items and actuator updates checked against a shadow table.
// Depends on lct_pkg and the linkage_code_table_unit RTL.
module tb_linkage_code_table_unit
  import lct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int EPISODE_LEN = 100;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOT_CODES = 3;
  localparam int COLD_MAX = 20;
  // The kind encoding the block leaves unused.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    lct_item_t   item;
    bit          pinned;
    lct_result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_req;
  lct_item_t   item_req;
  logic        busy_o;
  logic        result_valid_o;
  lct_result_t result_o;

  // Expectation typed into the directed table, launched along with the item.
  bit          pin_req;
  lct_result_t pin_want;

  // Shadow copy of the code table.
  logic [CODE_W-1:0]  tbl_code  [DEPTH];
  logic [COUNT_W-1:0] tbl_count [DEPTH];
  logic               tbl_act   [DEPTH];
  logic               tbl_ext   [DEPTH];
  logic               tbl_intl  [DEPTH];
  logic [LSN_W-1:0]   tbl_lsn   [DEPTH];
  logic               gen_flag;

  lct_result_t pending_results[$];
  dir_row_t    directed_rows[$];

  logic [CODE_W-1:0] hot_pool [HOT_CODES];
  logic [CODE_W-1:0] cold_pool [COLD_MAX];
  int cold_size;

  int mismatch_count;
  int results_checked;
  int items_sent;
  int aged_seen;
  int outcome_tally [8];

  linkage_code_table_unit #(
    .TABLE_ENTRIES(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_req),
    .item_i        (item_req),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic lct_item_t mk_item(logic [1:0] kind, logic [CODE_W-1:0] code,
                                        logic act, logic ext, logic intl,
                                        logic [LSN_W-1:0] lsn);
    lct_item_t it;
    it.kind = kind;
    it.program_code = code;
    it.actuator_bit = act;
    it.extended_bit = ext;
    it.international_bit = intl;
    it.set_number = lsn;
    return it;
  endfunction

  function automatic lct_result_t mk_result(lct_status_e status, int slot, logic gen,
                                            int occ, logic aged);
    lct_result_t res;
    res.status = status;
    res.slot = SLOT_W'(slot);
    res.general_actuator = gen;
    res.occupied = OCC_W'(occ);
    res.aged = aged;
    return res;
  endfunction

  function automatic void add_row(lct_item_t it, bit pinned, lct_result_t want);
    dir_row_t row;
    row.item = it;
    row.pinned = pinned;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic int entries_in_use();
    int n;
    n = 0;
    while (n < DEPTH && tbl_count[n] != '0) n++;
    return n;
  endfunction

  function automatic int find_code(logic [CODE_W-1:0] code, int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (tbl_code[i] == code) break;
    end
    return i;
  endfunction

  // Halves every count, removes entries that reach zero and packs the rest to the
  // front in their old order; returns where the tracked entry ended up.
  function automatic int halve_and_compact(int track);
    int n;
    int w;
    int moved;
    logic [COUNT_W-1:0] c;
    n = entries_in_use();
    w = 0;
    moved = 0;
    for (int r = 0; r < n; r++) begin
      c = tbl_count[r] >> 1;
      if (c != '0) begin
        if (r == track) moved = w;
        tbl_code[w]  = tbl_code[r];
        tbl_count[w] = c;
        tbl_act[w]   = tbl_act[r];
        tbl_ext[w]   = tbl_ext[r];
        tbl_intl[w]  = tbl_intl[r];
        tbl_lsn[w]   = tbl_lsn[r];
        w++;
      end
    end
    for (int r = w; r < n; r++) begin
      tbl_code[r]  = '0;
      tbl_count[r] = '0;
    end
    return moved;
  endfunction

  function automatic lct_result_t apply_to_shadow_table(lct_item_t it);
    lct_result_t res;
    int n;
    int i;
    int m;
    bit take;
    bit any_act;
    res = mk_result(STATUS_MISS, 0, 1'b0, 0, 1'b0);
    n = entries_in_use();
    case (it.kind)
      KIND_OBSERVE: begin
        take = 1'b1;
        i = find_code(it.program_code, n);
        if (i < n) begin
          res.status = STATUS_HIT;
        end else if (n < DEPTH) begin
          i = n;
          tbl_code[i] = it.program_code;
          res.status = STATUS_INSERTED;
        end else begin
          // Full table: the first entry with the lowest count is the victim.
          m = 0;
          for (int k = 1; k < DEPTH; k++) begin
            if (tbl_count[k] < tbl_count[m]) m = k;
          end
          if (tbl_count[m] < REPLACE_BELOW) begin
            i = m;
            tbl_code[i] = it.program_code;
            res.status = STATUS_REPLACED;
          end else begin
            take = 1'b0;
          end
        end
        if (take) begin
          tbl_count[i] = tbl_count[i] + 1'b1;
          res.slot = SLOT_W'(i);
          if (tbl_count[i] >= AGE_LIMIT) begin
            res.slot = SLOT_W'(halve_and_compact(i));
            res.aged = 1'b1;
          end
        end
      end
      KIND_LINK: begin
        i = find_code(it.program_code, n);
        if (i < n) begin
          tbl_act[i]  = it.actuator_bit;
          tbl_ext[i]  = it.extended_bit;
          tbl_intl[i] = it.international_bit;
          tbl_lsn[i]  = it.set_number;
          res.status = STATUS_HIT;
          res.slot = SLOT_W'(i);
          if (it.actuator_bit) begin
            gen_flag = 1'b1;
          end else begin
            any_act = 1'b0;
            for (int k = 0; k < n; k++) begin
              if (tbl_act[k]) any_act = 1'b1;
            end
            if (!any_act) gen_flag = 1'b0;
          end
        end
      end
      KIND_ACTUATE: begin
        gen_flag = it.actuator_bit;
        if (!it.actuator_bit) begin
          for (int k = 0; k < DEPTH; k++) tbl_act[k] = 1'b0;
        end
        res.status = STATUS_ACTUATOR;
      end
      default: ;
    endcase
    res.general_actuator = gen_flag;
    res.occupied = OCC_W'(entries_in_use());
    return res;
  endfunction

  // Half of the pool draws go to a few long-lived codes so that counts climb to
  // the aging point; the rest spread over codes that change from episode to episode.
  function automatic logic [CODE_W-1:0] pick_pool_code();
    if ($urandom_range(0, 1) == 0) return hot_pool[$urandom_range(0, HOT_CODES - 1)];
    return cold_pool[$urandom_range(0, cold_size - 1)];
  endfunction

  function automatic lct_item_t pick_random_item();
    lct_item_t it;
    int r;
    it = mk_item(KIND_OBSERVE, CODE_W'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom), LSN_W'($urandom));
    r = $urandom_range(0, 99);
    if (r < 65) begin
      if ($urandom_range(0, 9) != 0) it.program_code = pick_pool_code();
    end else if (r < 87) begin
      it.kind = KIND_LINK;
      if ($urandom_range(0, 4) != 0) it.program_code = pick_pool_code();
    end else if (r < 97) begin
      it.kind = KIND_ACTUATE;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns: result %0d: %s", $time, results_checked, msg);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_req <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(lct_item_t it, bit pinned, lct_result_t want);
    @(negedge clk_i);
    start_req <= 1'b1;
    item_req  <= it;
    pin_req   <= pinned;
    pin_want  <= want;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk_i) begin
    lct_result_t want;
    lct_result_t predicted;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transfer outstanding");
        end else begin
          want = pending_results.pop_front();
          if (result_o.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_o.status, want.status));
          if (result_o.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", result_o.slot, want.slot));
          if (result_o.general_actuator !== want.general_actuator)
            report_mismatch($sformatf("general_actuator %b, expected %b",
                                      result_o.general_actuator, want.general_actuator));
          if (result_o.occupied !== want.occupied)
            report_mismatch($sformatf("occupied %0d, expected %0d",
                                      result_o.occupied, want.occupied));
          if (result_o.aged !== want.aged)
            report_mismatch($sformatf("aged %b, expected %b", result_o.aged, want.aged));
        end
      end
      if (start_req && !busy_o) begin
        predicted = apply_to_shadow_table(item_req);
        outcome_tally[predicted.status]++;
        if (predicted.aged) aged_seen++;
        pending_results.push_back(pin_req ? pin_want : predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    int idle_cycles;
    if ((start_req && !busy_o) || result_valid_o === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer or result", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    lct_result_t none;
    bit calm;
    int sent_random;
    rst_ni    = 1'b0;
    start_req = 1'b0;
    item_req  = '0;
    pin_req   = 1'b0;
    pin_want  = '0;
    none = '0;
    mismatch_count = 0;
    results_checked = 0;
    items_sent = 0;
    aged_seen = 0;
    foreach (outcome_tally[k]) outcome_tally[k] = 0;
    for (int k = 0; k < DEPTH; k++) begin
      tbl_code[k]  = '0;
      tbl_count[k] = '0;
      tbl_act[k]   = 1'b0;
      tbl_ext[k]   = 1'b0;
      tbl_intl[k]  = 1'b0;
      tbl_lsn[k]   = '0;
    end
    gen_flag = 1'b0;

    // Empty table: linkage misses, actuator set and clear, unused kind.
    add_row(mk_item(KIND_LINK, 16'h1234, 1'b1, 1'b1, 1'b1, 12'hABC), 1'b1,
            mk_result(STATUS_MISS, 0, 1'b0, 0, 1'b0));
    add_row(mk_item(KIND_ACTUATE, 16'h0000, 1'b1, 1'b0, 1'b0, 12'h000), 1'b1,
            mk_result(STATUS_ACTUATOR, 0, 1'b1, 0, 1'b0));
    add_row(mk_item(KIND_ACTUATE, 16'hFFFF, 1'b0, 1'b1, 1'b1, 12'hFFF), 1'b1,
            mk_result(STATUS_ACTUATOR, 0, 1'b0, 0, 1'b0));
    add_row(mk_item(KIND_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1'b1, 12'hFFF), 1'b1,
            mk_result(STATUS_MISS, 0, 1'b0, 0, 1'b0));
    // Code extremes, a hit, then linkage stores that set and clear the actuator.
    add_row(mk_item(KIND_OBSERVE, 16'h0000, 1'b0, 1'b0, 1'b0, 12'h000), 1'b1,
            mk_result(STATUS_INSERTED, 0, 1'b0, 1, 1'b0));
    add_row(mk_item(KIND_OBSERVE, 16'hFFFF, 1'b1, 1'b1, 1'b1, 12'hFFF), 1'b1,
            mk_result(STATUS_INSERTED, 1, 1'b0, 2, 1'b0));
    add_row(mk_item(KIND_OBSERVE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 12'h000), 1'b0, none);
    add_row(mk_item(KIND_LINK, 16'hFFFF, 1'b1, 1'b1, 1'b1, 12'hFFF), 1'b0, none);
    add_row(mk_item(KIND_LINK, 16'h0000, 1'b0, 1'b0, 1'b0, 12'h000), 1'b0, none);
    add_row(mk_item(KIND_LINK, 16'hFFFF, 1'b0, 1'b0, 1'b0, 12'h000), 1'b0, none);
    // Fill the table, then force a replacement of the first lowest-count entry.
    for (int k = 2; k < DEPTH; k++) begin
      add_row(mk_item(KIND_OBSERVE, CODE_W'(16'h0100 + k), 1'b0, 1'b0, 1'b0, 12'h000),
              1'b1, mk_result(STATUS_INSERTED, k, 1'b0, k + 1, 1'b0));
    end
    add_row(mk_item(KIND_OBSERVE, 16'h5A5A, 1'b0, 1'b0, 1'b0, 12'h000), 1'b0, none);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      hold_off(pick_gap(1'b0));
      send_item(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].want);
    end

    foreach (hot_pool[k]) hot_pool[k] = CODE_W'($urandom);
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      // Each episode brings fresh codes; a small pool fills the table with
      // entries of count two or more so that later strangers are dropped.
      cold_size = ($urandom_range(0, 1) == 0) ? 13 : COLD_MAX;
      for (int k = 0; k < cold_size; k++) cold_pool[k] = CODE_W'($urandom);
      calm = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < EPISODE_LEN; k++) begin
        hold_off(pick_gap(calm));
        send_item(pick_random_item(), 1'b0, none);
        sent_random++;
      end
    end

    @(negedge clk_i);
    start_req <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d directed), %0d results checked, %0d mismatches",
             items_sent, directed_rows.size(), results_checked, mismatch_count);
    $display("Hits %0d, inserts %0d, replacements %0d, misses/drops %0d, actuator %0d, aging %0d",
             outcome_tally[STATUS_HIT], outcome_tally[STATUS_INSERTED],
             outcome_tally[STATUS_REPLACED], outcome_tally[STATUS_MISS],
             outcome_tally[STATUS_ACTUATOR], aged_seen);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
